### hdl/rtqi_pkg.sv
// shared constants, types and arithmetic helpers for the ray/triangle/quad intersector
// no dependencies
package rtqi_pkg;

  localparam int COORD_BITS = 20;
  localparam int PACK_W     = 60;
  localparam int EPS_W      = 21;
  localparam int DIST_W     = 32;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1074);

  // edge, cross product, split product and dot product widths
  localparam int EW  = COORD_BITS + 1;
  localparam int XW  = 2 * EW + 1;
  localparam int SPL = (XW + 1) / 2;
  localparam int HW  = EW + XW - SPL;
  localparam int LW  = EW + SPL + 1;
  localparam int DW  = EW + XW + 2;
  localparam int NW  = DW + 1;

  // distance has 16 fraction bits, quotient is DIST_W bits
  localparam int FRAC_BITS  = 16;
  localparam int Q_W        = DIST_W;
  localparam int SH         = Q_W - FRAC_BITS;

  localparam int TRI_STAGES = 7;
  localparam int DIV_STAGES = Q_W;
  localparam int NUM_STAGES = TRI_STAGES + DIV_STAGES + 2;

  // dot product slots
  localparam int D_DET = 0;
  localparam int D_UN  = 1;
  localparam int D_VN  = 2;
  localparam int D_TN  = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed { coord_t z; coord_t y; coord_t x; } coord3_t;
  typedef struct packed {
    logic signed [EW-1:0] z;
    logic signed [EW-1:0] y;
    logic signed [EW-1:0] x;
  } edge3_t;
  typedef struct packed {
    logic signed [XW-1:0] z;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] x;
  } cross3_t;
  typedef struct packed {
    logic signed [HW-1:0] hi;
    logic signed [LW-1:0] lo;
  } part_t;
  typedef struct packed { part_t z; part_t y; part_t x; } part3_t;
  typedef struct packed {
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] x;
  } prod3_t;
  typedef struct packed {
    logic          hit;
    logic          tneg;
    logic [NW-1:0] tmag;
    logic [NW-1:0] det;
  } tri_res_t;
  typedef struct packed {
    logic           hit;
    logic           tneg;
    logic           sat;
    logic [NW-1:0]  det;
    logic [NW-1:0]  rem;
    logic [Q_W-1:0] nlow;
    logic [Q_W-1:0] q;
  } div_t;

  function automatic edge3_t vsub(coord3_t a, coord3_t b);
    edge3_t r;
    r.x = EW'(a.x) - EW'(b.x);
    r.y = EW'(a.y) - EW'(b.y);
    r.z = EW'(a.z) - EW'(b.z);
    return r;
  endfunction

  function automatic edge3_t vext(coord3_t a);
    edge3_t r;
    r.x = EW'(a.x);
    r.y = EW'(a.y);
    r.z = EW'(a.z);
    return r;
  endfunction

  function automatic cross3_t vcross(edge3_t a, edge3_t b);
    cross3_t r;
    logic signed [2*EW-1:0] p0, p1, p2, p3, p4, p5;
    p0 = a.y * b.z;
    p1 = a.z * b.y;
    p2 = a.z * b.x;
    p3 = a.x * b.z;
    p4 = a.x * b.y;
    p5 = a.y * b.x;
    r.x = XW'(p0) - XW'(p1);
    r.y = XW'(p2) - XW'(p3);
    r.z = XW'(p4) - XW'(p5);
    return r;
  endfunction

  // wide operand cut in a signed high half and an unsigned low half
  function automatic part_t mul_split(logic signed [EW-1:0] a, logic signed [XW-1:0] b);
    part_t r;
    r.hi = a * $signed(b[XW-1:SPL]);
    r.lo = a * $signed({1'b0, b[SPL-1:0]});
    return r;
  endfunction

  function automatic part3_t dot_split(edge3_t a, cross3_t b);
    part3_t r;
    r.x = mul_split(a.x, b.x);
    r.y = mul_split(a.y, b.y);
    r.z = mul_split(a.z, b.z);
    return r;
  endfunction

  function automatic logic signed [DW-1:0] part_full(part_t p);
    logic signed [DW-1:0] h;
    logic signed [DW-1:0] l;
    h = p.hi;
    l = p.lo;
    return (h <<< SPL) + l;
  endfunction

endpackage

### hdl/rtqi_if.sv
// valid/ready channels of the intersector: ray item, result item, epsilon write
// depends on rtqi_pkg
interface rtqi_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [rtqi_pkg::PACK_W-1:0]  ray_origin;
  logic [rtqi_pkg::PACK_W-1:0]  ray_direction;
  logic [rtqi_pkg::PACK_W-1:0]  vertex_zero;
  logic [rtqi_pkg::PACK_W-1:0]  vertex_one;
  logic [rtqi_pkg::PACK_W-1:0]  vertex_two;
  logic [rtqi_pkg::PACK_W-1:0]  vertex_three;
  modport source (output valid, mode, ray_origin, ray_direction, vertex_zero, vertex_one,
                  vertex_two, vertex_three, input ready);
  modport sink (input valid, mode, ray_origin, ray_direction, vertex_zero, vertex_one,
                vertex_two, vertex_three, output ready);
endinterface

interface rtqi_out_if;
  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic signed [rtqi_pkg::DIST_W-1:0] distance;
  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

interface rtqi_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rtqi_pkg::EPS_W-1:0] det_epsilon;
  modport source (output valid, det_epsilon, input ready);
  modport sink (input valid, det_epsilon, output ready);
endinterface

### hdl/rtqi_tri.sv
// moller-trumbore datapath for one triangle, seven register stages
// depends on rtqi_pkg; per-stage enables come from the top level
module rtqi_tri (
  input  logic                             clk,
  input  logic [rtqi_pkg::TRI_STAGES-1:0]  en,
  input  rtqi_pkg::coord3_t                org,
  input  rtqi_pkg::coord3_t                dir,
  input  rtqi_pkg::coord3_t                va,
  input  rtqi_pkg::coord3_t                vb,
  input  rtqi_pkg::coord3_t                vc,
  input  logic [rtqi_pkg::EPS_W-1:0]       det_epsilon,
  output rtqi_pkg::tri_res_t               res
);

  rtqi_pkg::edge3_t  e1_1, e2_1, tv_1, d_1;
  rtqi_pkg::edge3_t  e1_2, e2_2, tv_2, d_2;
  rtqi_pkg::cross3_t pv_2, qv_2;
  rtqi_pkg::part3_t  pp_3 [4];
  rtqi_pkg::prod3_t  pr_4 [4];
  logic signed [rtqi_pkg::DW-1:0] sum_5 [4];
  logic signed [rtqi_pkg::NW-1:0] det_6, un_6, vn_6, tn_6;

  logic signed [rtqi_pkg::NW-1:0] det_x, un_x, vn_x, tn_x;
  logic signed [rtqi_pkg::NW:0]   uv_sum, det_w;
  logic signed [rtqi_pkg::NW-1:0] tn_abs;
  logic                           miss;

  // edges and origin offset
  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1_1 <= rtqi_pkg::vsub(vb, va);
      e2_1 <= rtqi_pkg::vsub(vc, va);
      tv_1 <= rtqi_pkg::vsub(org, va);
      d_1  <= rtqi_pkg::vext(dir);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pv_2 <= rtqi_pkg::vcross(d_1, e2_1);
      qv_2 <= rtqi_pkg::vcross(tv_1, e1_1);
      e1_2 <= e1_1;
      e2_2 <= e2_1;
      tv_2 <= tv_1;
      d_2  <= d_1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pp_3[rtqi_pkg::D_DET] <= rtqi_pkg::dot_split(e1_2, pv_2);
      pp_3[rtqi_pkg::D_UN]  <= rtqi_pkg::dot_split(tv_2, pv_2);
      pp_3[rtqi_pkg::D_VN]  <= rtqi_pkg::dot_split(d_2, qv_2);
      pp_3[rtqi_pkg::D_TN]  <= rtqi_pkg::dot_split(e2_2, qv_2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 4; k++) begin
        pr_4[k].x <= rtqi_pkg::part_full(pp_3[k].x);
        pr_4[k].y <= rtqi_pkg::part_full(pp_3[k].y);
        pr_4[k].z <= rtqi_pkg::part_full(pp_3[k].z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < 4; k++) begin
        sum_5[k] <= pr_4[k].x + pr_4[k].y + pr_4[k].z;
      end
    end
  end

  // make det positive, flipping the numerators along with it
  always_comb begin
    det_x = rtqi_pkg::NW'(sum_5[rtqi_pkg::D_DET]);
    un_x  = rtqi_pkg::NW'(sum_5[rtqi_pkg::D_UN]);
    vn_x  = rtqi_pkg::NW'(sum_5[rtqi_pkg::D_VN]);
    tn_x  = rtqi_pkg::NW'(sum_5[rtqi_pkg::D_TN]);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (det_x[rtqi_pkg::NW-1]) begin
        det_6 <= -det_x;
        un_6  <= -un_x;
        vn_6  <= -vn_x;
        tn_6  <= -tn_x;
      end else begin
        det_6 <= det_x;
        un_6  <= un_x;
        vn_6  <= vn_x;
        tn_6  <= tn_x;
      end
    end
  end

  always_comb begin
    uv_sum = (rtqi_pkg::NW+1)'(un_6) + (rtqi_pkg::NW+1)'(vn_6);
    det_w  = (rtqi_pkg::NW+1)'(det_6);
    tn_abs = tn_6[rtqi_pkg::NW-1] ? -tn_6 : tn_6;
    miss   = (det_6 == '0)
          || ($unsigned(det_6) < rtqi_pkg::NW'(det_epsilon))
          || un_6[rtqi_pkg::NW-1] || (un_6 > det_6)
          || vn_6[rtqi_pkg::NW-1] || (uv_sum > det_w);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      res.hit  <= !miss;
      res.tneg <= tn_6[rtqi_pkg::NW-1];
      res.tmag <= $unsigned(tn_abs);
      res.det  <= $unsigned(det_6);
    end
  end

endmodule

### hdl/ray_triangle_quad_intersect_top.sv
// ray against triangle or quad, moller-trumbore, pipelined with a radix-2 divider
// depends on rtqi_pkg, rtqi_if and rtqi_tri
//
//   channel  dir  handshake       payload
//   ray      in   valid / ready   mode, ray_origin, ray_direction, vertex_zero..three
//   result   out  valid / ready   hit, distance
//   cfg      in   valid / ready   det_epsilon (ready always high)
//
// one item per cycle while results are taken; stages: 7 triangle stages (both triangles side by
// side), 1 select stage, 32 divider stages at one quotient bit each, 1 output stage.
// rst is synchronous and clears the valid bits and det_epsilon (to 1074).
// a stage moves when it is empty or the stage after it moves, so bubbles close up
// behind a stalled result and input is taken while the pipeline has room.
module ray_triangle_quad_intersect_top (
  input logic        clk,
  input logic        rst,
  rtqi_in_if.sink    ray,
  rtqi_out_if.source result,
  rtqi_cfg_if.sink   cfg
);

  localparam int NS = rtqi_pkg::NUM_STAGES;
  localparam int TS = rtqi_pkg::TRI_STAGES;
  localparam int QW = rtqi_pkg::Q_W;
  localparam int NW = rtqi_pkg::NW;
  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

  logic [NS:0]   en;
  logic [NS-1:0] vld;
  logic [rtqi_pkg::EPS_W-1:0] det_epsilon;
  logic          mode_p [TS];

  rtqi_pkg::coord3_t  org, dir, v0, v1, v2, v3;
  rtqi_pkg::tri_res_t res_a, res_b, res_sel;
  rtqi_pkg::div_t     dq [rtqi_pkg::DIV_STAGES+1];
  logic               hit_sel;

  // one restoring division step
  function automatic rtqi_pkg::div_t div_step(rtqi_pkg::div_t d);
    rtqi_pkg::div_t n;
    logic [NW:0]    r2;
    n      = d;
    r2     = {d.rem, d.nlow[QW-1]};
    n.nlow = d.nlow << 1;
    if (r2 >= {1'b0, d.det}) begin
      n.rem = NW'(r2 - {1'b0, d.det});
      n.q   = {d.q[QW-2:0], 1'b1};
    end else begin
      n.rem = r2[NW-1:0];
      n.q   = {d.q[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    en[NS] = result.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign ray.ready    = en[0];
  assign result.valid = vld[NS-1];
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= ray.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= rtqi_pkg::EPS_RESET;
    end else if (cfg.valid) begin
      det_epsilon <= cfg.det_epsilon;
    end
  end

  assign org = rtqi_pkg::coord3_t'(ray.ray_origin[3*rtqi_pkg::COORD_BITS-1:0]);
  assign dir = rtqi_pkg::coord3_t'(ray.ray_direction[3*rtqi_pkg::COORD_BITS-1:0]);
  assign v0  = rtqi_pkg::coord3_t'(ray.vertex_zero[3*rtqi_pkg::COORD_BITS-1:0]);
  assign v1  = rtqi_pkg::coord3_t'(ray.vertex_one[3*rtqi_pkg::COORD_BITS-1:0]);
  assign v2  = rtqi_pkg::coord3_t'(ray.vertex_two[3*rtqi_pkg::COORD_BITS-1:0]);
  assign v3  = rtqi_pkg::coord3_t'(ray.vertex_three[3*rtqi_pkg::COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_p[0] <= ray.mode;
    end
    for (int k = 1; k < TS; k++) begin
      if (en[k]) begin
        mode_p[k] <= mode_p[k-1];
      end
    end
  end

  rtqi_tri u_tri_a (
    .clk         (clk),
    .en          (en[TS-1:0]),
    .org         (org),
    .dir         (dir),
    .va          (v0),
    .vb          (v1),
    .vc          (v2),
    .det_epsilon (det_epsilon),
    .res         (res_a)
  );

  rtqi_tri u_tri_b (
    .clk         (clk),
    .en          (en[TS-1:0]),
    .org         (org),
    .dir         (dir),
    .va          (v0),
    .vb          (v2),
    .vc          (v3),
    .det_epsilon (det_epsilon),
    .res         (res_b)
  );

  // first triangle wins; second only counts in quad mode
  always_comb begin
    hit_sel = res_a.hit || (mode_p[TS-1] && res_b.hit);
    res_sel = res_a.hit ? res_a : res_b;
  end

  always_ff @(posedge clk) begin
    if (en[TS]) begin
      dq[0].hit  <= hit_sel;
      dq[0].tneg <= res_sel.tneg;
      dq[0].sat  <= {res_sel.tmag} >= {res_sel.det, {rtqi_pkg::SH{1'b0}}};
      dq[0].det  <= res_sel.det;
      dq[0].rem  <= res_sel.tmag >> rtqi_pkg::SH;
      dq[0].nlow <= {res_sel.tmag[rtqi_pkg::SH-1:0], {rtqi_pkg::FRAC_BITS{1'b0}}};
      dq[0].q    <= '0;
    end
  end

  for (genvar j = 0; j < rtqi_pkg::DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[TS+1+j]) begin
        dq[j+1] <= div_step(dq[j]);
      end
    end
  end

  // saturate to the q16.16 range and apply the sign
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result.hit <= dq[rtqi_pkg::DIV_STAGES].hit;
      if (!dq[rtqi_pkg::DIV_STAGES].hit) begin
        result.distance <= '0;
      end else if (dq[rtqi_pkg::DIV_STAGES].tneg) begin
        if (dq[rtqi_pkg::DIV_STAGES].sat || (dq[rtqi_pkg::DIV_STAGES].q > NEG_MIN)) begin
          result.distance <= $signed(NEG_MIN);
        end else begin
          result.distance <= $signed(-dq[rtqi_pkg::DIV_STAGES].q);
        end
      end else begin
        if (dq[rtqi_pkg::DIV_STAGES].sat || dq[rtqi_pkg::DIV_STAGES].q[QW-1]) begin
          result.distance <= $signed(POS_MAX);
        end else begin
          result.distance <= $signed(dq[rtqi_pkg::DIV_STAGES].q);
        end
      end
    end
  end

endmodule

### hdl/rtqi_checker.sv
// port-level checks for the intersector, bound to the top level
// depends on rtqi_pkg and ray_triangle_quad_intersect_top
module rtqi_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               ray_valid,
  input logic                               ray_ready,
  input logic                               result_valid,
  input logic                               result_ready,
  input logic                               hit,
  input logic signed [rtqi_pkg::DIST_W-1:0] distance
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(hit) && $stable(distance))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !hit |-> distance == '0)
    else $error("miss with nonzero distance");

  // input only backs up when the pipeline is full behind a stalled result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    ray_valid && !ray_ready |-> result_valid && !result_ready)
    else $error("input refused with room in pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind ray_triangle_quad_intersect_top rtqi_checker u_rtqi_checker (
  .clk          (clk),
  .rst          (rst),
  .ray_valid    (ray.valid),
  .ray_ready    (ray.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .hit          (result.hit),
  .distance     (result.distance)
);
